// File: design/end_pkg.sv
// Package: shared types and constants for the encoded number decoder.
package end_pkg;

    typedef enum logic [1:0] {
        KIND_INT     = 2'd0,
        KIND_REAL    = 2'd1,
        KIND_INVALID = 2'd2
    } t_kind;

    localparam logic [2:0] TYPE_FIX32A = 3'd0;
    localparam logic [2:0] TYPE_FIX32B = 3'd1;
    localparam logic [2:0] TYPE_FIX16  = 3'd2;
    localparam logic [2:0] TYPE_IEEE   = 3'd3;

    localparam logic [7:0] EXP_BIAS = 8'd127;

    typedef struct packed {
        logic [7:0] byte_first;
        logic [7:0] byte_second;
        logic [7:0] byte_third;
        logic [7:0] byte_fourth;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] int_value;
        logic [31:0]        real_bits;
    } t_out_beat;

endpackage

// File: design/end_to_single.sv
// Module: scaled fixed-point to IEEE single conversion, round to nearest even.
module end_to_single (
    input  logic [31:0] i_raw,
    input  logic [4:0]  i_scale,
    output logic [31:0] o_bits
);
    logic        sign;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic [31:0] norm;
    logic [23:0] keep;
    logic        guard;
    logic        sticky;
    logic [24:0] rounded;
    logic [7:0]  expo;

    // Find leading one: priority encode, the highest set bit wins.
    always_comb begin
        msb = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (mag[k]) msb = 5'(k);
        end
    end

    always_comb begin
        sign    = i_raw[31];
        mag     = sign ? (32'd0 - i_raw) : i_raw;
        // Left-justify so the leading one sits at bit 31.
        norm    = mag << (5'd31 - msb);
        keep    = norm[31:8];
        guard   = norm[7];
        sticky  = |norm[6:0];
        rounded = {1'b0, keep} + 25'(guard & (sticky | keep[0]));
        expo    = 8'(msb) + end_pkg::EXP_BIAS - 8'(i_scale) + 8'(rounded[24]);
        if (mag == 32'd0) begin
            o_bits = 32'd0;
        end else if (rounded[24]) begin
            o_bits = {sign, expo, rounded[23:1]};
        end else begin
            o_bits = {sign, expo, rounded[22:0]};
        end
    end
endmodule

// File: design/encoded_number_decoder.sv
// Top level: binary encoded number decoder, one number per clock.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  input   | in        | i_start, o_busy       | i_in (t_in_beat, four bytes)
//  result  | out       | o_done strobe         | o_out (t_out_beat)
//  config  | in        | i_cfg_we              | i_cfg_data (number_format)
//
// A beat is taken on every edge with i_start high; o_busy is tied low because
// the byte-assembly and conversion logic ahead of the result register accepts
// a new beat each cycle. The result is registered and shows in the cycle after
// acceptance, with o_done high for exactly that cycle; the receiver cannot
// stall it. Synchronous active-low reset clears the strobe and the format.
module encoded_number_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  end_pkg::t_in_beat   i_in,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    output logic                o_done,
    output end_pkg::t_out_beat  o_out
);
    logic [7:0]         r_fmt;
    logic               r_done;
    end_pkg::t_out_beat r_out;
    end_pkg::t_out_beat n_out;

    logic        lsb_first;
    logic [2:0]  fmt_type;
    logic [31:0] word32;
    logic [31:0] word16;
    logic [31:0] fix_raw;
    logic [4:0]  fix_scale;
    logic [31:0] single_bits;

    assign lsb_first = r_fmt[7];
    assign fmt_type  = r_fmt[6:4];

    // Assemble words in the selected byte order; 16-bit form sign-extends.
    always_comb begin
        if (lsb_first) begin
            word32 = {i_in.byte_fourth, i_in.byte_third, i_in.byte_second, i_in.byte_first};
            word16 = {{16{i_in.byte_second[7]}}, i_in.byte_second, i_in.byte_first};
        end else begin
            word32 = {i_in.byte_first, i_in.byte_second, i_in.byte_third, i_in.byte_fourth};
            word16 = {{16{i_in.byte_first[7]}}, i_in.byte_first, i_in.byte_second};
        end
    end

    always_comb begin
        if (fmt_type == end_pkg::TYPE_FIX16) begin
            fix_raw   = word16;
            fix_scale = {1'b0, r_fmt[3:0]};
        end else begin
            fix_raw   = word32;
            fix_scale = r_fmt[4:0];
        end
    end

    end_to_single u_to_single (
        .i_raw   (fix_raw),
        .i_scale (fix_scale),
        .o_bits  (single_bits)
    );

    // Pick the result kind; unused value fields drop to zero.
    always_comb begin
        n_out = '0;
        unique case (fmt_type)
            end_pkg::TYPE_FIX32A, end_pkg::TYPE_FIX32B, end_pkg::TYPE_FIX16: begin
                if (fix_scale == 5'd0) begin
                    n_out.result_kind = end_pkg::KIND_INT;
                    n_out.int_value   = fix_raw;
                end else begin
                    n_out.result_kind = end_pkg::KIND_REAL;
                    n_out.real_bits   = single_bits;
                end
            end
            end_pkg::TYPE_IEEE: begin
                n_out.result_kind = end_pkg::KIND_REAL;
                n_out.real_bits   = word32;
            end
            default: begin
                n_out.result_kind = end_pkg::KIND_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= 8'd0;
            r_done <= 1'b0;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_data;
            r_done <= i_start;
        end
    end

    // Hold the payload register unreset; it is qualified by the strobe.
    always_ff @(posedge i_clk) begin
        if (i_start) r_out <= n_out;
    end

    assign o_busy = 1'b0;
    assign o_done = r_done;
    assign o_out  = r_out;
endmodule
